// ----- design/kdhr_pkg.sv -----
package kdhr_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int KEY_WIDTH = 5;
	localparam int KEY_CODES = 32;
	localparam int DEBOUNCE_WIDTH = 7;
	localparam int HOLD_WIDTH = 16;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int TDATA_WIDTH = 8;
	localparam int TUSER_WIDTH = 2;
	localparam int REPEAT_BITS = 4;

	localparam logic [KEY_WIDTH-1:0] RESET_NO_KEY = KEY_WIDTH'(31);
	localparam logic [DEBOUNCE_WIDTH-1:0] RESET_DEBOUNCE = DEBOUNCE_WIDTH'(2);
	localparam logic [HOLD_WIDTH-1:0] RESET_HOLD = HOLD_WIDTH'(128);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_NO_KEY = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_MASK = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_MASK = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD = 3'd4;

	typedef struct packed {
		logic [KEY_WIDTH-1:0]      no_key_code;
		logic [KEY_CODES-1:0]      hold_key_mask;
		logic [KEY_CODES-1:0]      repeat_key_mask;
		logic [DEBOUNCE_WIDTH-1:0] debounce_count;
		logic [HOLD_WIDTH-1:0]     hold_count;
	} cfg_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] event_key;
		logic                 pressed;
		logic                 held;
	} evt_t;

endpackage

// ----- design/kdhr_cfg.sv -----
module kdhr_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [kdhr_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [kdhr_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
	output kdhr_pkg::cfg_t                       cfg
);

	kdhr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.no_key_code     <= kdhr_pkg::RESET_NO_KEY;
			cfg_q.hold_key_mask   <= '0;
			cfg_q.repeat_key_mask <= '0;
			cfg_q.debounce_count  <= kdhr_pkg::RESET_DEBOUNCE;
			cfg_q.hold_count      <= kdhr_pkg::RESET_HOLD;
		end else if (wr_en) begin
			unique case (wr_index)
				kdhr_pkg::REG_NO_KEY: begin
					cfg_q.no_key_code <= wr_data[kdhr_pkg::KEY_WIDTH-1:0];
				end
				kdhr_pkg::REG_HOLD_MASK: begin
					cfg_q.hold_key_mask <= wr_data[kdhr_pkg::KEY_CODES-1:0];
				end
				kdhr_pkg::REG_REPEAT_MASK: begin
					cfg_q.repeat_key_mask <= wr_data[kdhr_pkg::KEY_CODES-1:0];
				end
				kdhr_pkg::REG_DEBOUNCE: begin
					cfg_q.debounce_count <= wr_data[kdhr_pkg::DEBOUNCE_WIDTH-1:0];
				end
				kdhr_pkg::REG_HOLD: begin
					cfg_q.hold_count <= wr_data[kdhr_pkg::HOLD_WIDTH-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/kdhr_step.sv -----
module kdhr_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [kdhr_pkg::KEY_WIDTH-1:0] key,
	input  kdhr_pkg::cfg_t                 cfg,
	output logic                           evt_valid,
	output kdhr_pkg::evt_t                 evt
);

	logic [kdhr_pkg::KEY_WIDTH-1:0]   last_q, last_d;
	logic [kdhr_pkg::KEY_WIDTH-1:0]   confirmed_q, confirmed_d;
	logic                             hold_flag_q, hold_flag_d;
	logic [kdhr_pkg::COUNT_WIDTH-1:0] count_q, count_d;
	logic [kdhr_pkg::COUNT_WIDTH-1:0] count_inc;
	logic [kdhr_pkg::COUNT_WIDTH-1:0] debounce_ext;
	logic [kdhr_pkg::COUNT_WIDTH-1:0] hold_ext;
	logic                             is_no_key;

	assign count_inc    = count_q + kdhr_pkg::COUNT_WIDTH'(1);
	assign debounce_ext = kdhr_pkg::COUNT_WIDTH'(cfg.debounce_count);
	assign hold_ext     = kdhr_pkg::COUNT_WIDTH'(cfg.hold_count);
	assign is_no_key    = (key == cfg.no_key_code);

	always_comb begin
		last_d        = last_q;
		confirmed_d   = confirmed_q;
		hold_flag_d   = hold_flag_q;
		count_d       = count_q;
		evt_valid     = 1'b0;
		evt.event_key = confirmed_q;
		evt.pressed   = 1'b0;
		evt.held      = hold_flag_q;
		if (key != last_q) begin
			if ((last_q != cfg.no_key_code) && !is_no_key) begin
				evt_valid = 1'b1;
			end
			last_d  = key;
			count_d = '0;
		end else begin
			count_d = count_inc;
			priority if (count_inc == debounce_ext) begin
				if (is_no_key) begin
					if (confirmed_q != cfg.no_key_code) begin
						evt_valid   = 1'b1;
						confirmed_d = cfg.no_key_code;
					end
				end else begin
					confirmed_d   = key;
					evt_valid     = 1'b1;
					evt.event_key = key;
					evt.pressed   = 1'b1;
					evt.held      = 1'b0;
				end
				hold_flag_d = 1'b0;
			end else if (count_inc == hold_ext) begin
				if (cfg.hold_key_mask[key]) begin
					hold_flag_d   = 1'b1;
					evt_valid     = 1'b1;
					evt.event_key = key;
					evt.pressed   = 1'b1;
					evt.held      = 1'b1;
				end
			end else if (count_inc > hold_ext) begin
				if (cfg.repeat_key_mask[key]) begin
					hold_flag_d   = 1'b1;
					evt.event_key = key;
					evt.pressed   = 1'b1;
					evt.held      = 1'b1;
					evt_valid     = (count_inc[kdhr_pkg::REPEAT_BITS-1:0] == '0);
				end
				if (count_inc == kdhr_pkg::COUNT_MAX) begin
					count_d = hold_ext;
				end
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q      <= kdhr_pkg::RESET_NO_KEY;
			confirmed_q <= kdhr_pkg::RESET_NO_KEY;
			hold_flag_q <= 1'b0;
			count_q     <= '0;
		end else if (en) begin
			last_q      <= last_d;
			confirmed_q <= confirmed_d;
			hold_flag_q <= hold_flag_d;
			count_q     <= count_d;
		end
	end

endmodule

// ----- design/kdhr_out.sv -----
module kdhr_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           evt_valid,
	input  kdhr_pkg::evt_t evt,
	input  logic           take,
	output logic           out_valid,
	output kdhr_pkg::evt_t out_evt
);

	logic           valid_q;
	kdhr_pkg::evt_t evt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= evt_valid;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && evt_valid) begin
			evt_q <= evt;
		end
	end

	assign out_valid = valid_q;
	assign out_evt   = evt_q;

endmodule

// ----- design/keypad_debounce_hold_repeat_core.sv -----
// A sample accepted on the input is held in the input register; when the output register
// is free or being taken, its event, if any, is computed and loaded into the output register.
// Throughput: one sample per cycle while the output is not stalled, set by the counter update
// and compares, which are combinational between the input register and the output register.
// Reset: arst_n asynchronously resets the valid flags, step state and config registers to their
// defaults; the key and event data registers are not reset. No result is pending after reset.
module keypad_debounce_hold_repeat_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [kdhr_pkg::TDATA_WIDTH-1:0]     s_axis_tdata,  // [4:0] sampled_key
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [kdhr_pkg::TDATA_WIDTH-1:0]     m_axis_tdata,  // [4:0] event_key
	output logic [kdhr_pkg::TUSER_WIDTH-1:0]     m_axis_tuser,  // [0] pressed, [1] held
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kdhr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [kdhr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	logic                           valid_s1;
	logic [kdhr_pkg::KEY_WIDTH-1:0] key_s1;
	logic                           adv;
	logic                           evt_valid;
	kdhr_pkg::evt_t                 evt;
	kdhr_pkg::evt_t                 out_evt;
	kdhr_pkg::cfg_t                 cfg;

	assign cfg_ready     = 1'b1;
	assign adv           = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			key_s1 <= s_axis_tdata[kdhr_pkg::KEY_WIDTH-1:0];
		end
	end

	kdhr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	kdhr_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.key       (key_s1),
		.cfg       (cfg),
		.evt_valid (evt_valid),
		.evt       (evt)
	);

	kdhr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.evt_valid (evt_valid),
		.evt       (evt),
		.take      (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_evt   (out_evt)
	);

	assign m_axis_tdata = kdhr_pkg::TDATA_WIDTH'(out_evt.event_key);
	assign m_axis_tuser = {out_evt.held, out_evt.pressed};

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

	import kdhr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_SAMPLES = 100;
	localparam int RANDOM_SAMPLES = 600;

	class key_event_predictor;
		logic [KEY_WIDTH-1:0]      no_key;
		logic [KEY_CODES-1:0]      hold_mask;
		logic [KEY_CODES-1:0]      repeat_mask;
		logic [DEBOUNCE_WIDTH-1:0] debounce;
		logic [HOLD_WIDTH-1:0]     hold;
		logic [KEY_WIDTH-1:0]      last_sample;
		logic [KEY_WIDTH-1:0]      confirmed;
		logic                      hold_flag;
		logic [COUNT_WIDTH-1:0]    stable_count;
		evt_t                      pending_events[$];
		int                        errors;
		int                        events_seen;

		function new();
			no_key = RESET_NO_KEY;
			hold_mask = '0;
			repeat_mask = '0;
			debounce = RESET_DEBOUNCE;
			hold = RESET_HOLD;
			last_sample = RESET_NO_KEY;
			confirmed = RESET_NO_KEY;
			hold_flag = 1'b0;
			stable_count = '0;
			errors = 0;
			events_seen = 0;
		endfunction

		function void flag(string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endfunction

		function void push_event(logic [KEY_WIDTH-1:0] key, logic pressed, logic held);
			evt_t e;
			e.event_key = key;
			e.pressed = pressed;
			e.held = held;
			pending_events.push_back(e);
		endfunction

		function void apply_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
			case (idx)
				REG_NO_KEY: no_key = val[KEY_WIDTH-1:0];
				REG_HOLD_MASK: hold_mask = val[KEY_CODES-1:0];
				REG_REPEAT_MASK: repeat_mask = val[KEY_CODES-1:0];
				REG_DEBOUNCE: debounce = val[DEBOUNCE_WIDTH-1:0];
				REG_HOLD: hold = val[HOLD_WIDTH-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [KEY_WIDTH-1:0] key);
			if (key != last_sample) begin
				if (last_sample != no_key && key != no_key)
					push_event(confirmed, 1'b0, hold_flag);
				last_sample = key;
				stable_count = '0;
				return;
			end
			stable_count = stable_count + 1'b1;
			if (stable_count == COUNT_WIDTH'(debounce)) begin
				if (key == no_key) begin
					if (confirmed != no_key) begin
						push_event(confirmed, 1'b0, hold_flag);
						confirmed = no_key;
					end
				end else begin
					confirmed = key;
					push_event(key, 1'b1, 1'b0);
				end
				hold_flag = 1'b0;
			end else if (stable_count == COUNT_WIDTH'(hold)) begin
				if (hold_mask[key]) begin
					hold_flag = 1'b1;
					push_event(key, 1'b1, 1'b1);
				end
			end else if (stable_count > COUNT_WIDTH'(hold)) begin
				if (repeat_mask[key]) begin
					hold_flag = 1'b1;
					if (stable_count[REPEAT_BITS-1:0] == '0)
						push_event(key, 1'b1, 1'b1);
				end
				if (stable_count == COUNT_MAX)
					stable_count = COUNT_WIDTH'(hold);
			end
		endfunction

		function void check_event(evt_t got);
			evt_t want;
			events_seen++;
			if (pending_events.size() == 0) begin
				flag($sformatf("unexpected event: expected none, actual key=%0d pressed=%0b held=%0b",
					got.event_key, got.pressed, got.held));
				return;
			end
			want = pending_events.pop_front();
			if (got.event_key !== want.event_key)
				flag($sformatf("event_key expected %0d actual %0d", want.event_key, got.event_key));
			if (got.pressed !== want.pressed)
				flag($sformatf("pressed expected %0b actual %0b", want.pressed, got.pressed));
			if (got.held !== want.held)
				flag($sformatf("held expected %0b actual %0b", want.held, got.held));
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_axis_tvalid;
	logic                       s_axis_tready;
	logic [TDATA_WIDTH-1:0]     s_axis_tdata;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready;
	logic [TDATA_WIDTH-1:0]     m_axis_tdata;
	logic [TUSER_WIDTH-1:0]     m_axis_tuser;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data;

	key_event_predictor tracker = new();

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_holdoff_req = 0;
	int items_sent = 0;
	int reg_writes = 0;
	int settings_used = 0;
	int quiet_cycles = 0;
	int directed_keys[20] = '{31, 31, 31, 0, 0, 0, 5, 5, 5, 31, 31, 31, 7, 9, 9, 9, 0, 31, 31, 31};

	keypad_debounce_hold_repeat_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int stall_left;
		evt_t got;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.event_key = m_axis_tdata[KEY_WIDTH-1:0];
				got.pressed = m_axis_tuser[0];
				got.held = m_axis_tuser[1];
				tracker.check_event(got);
			end
			if (rx_holdoff_req > 0) begin
				stall_left = rx_holdoff_req;
				rx_holdoff_req = 0;
			end else if (stall_left == 0 && rx_idle_pct > 0
					&& $urandom_range(0, 99) < rx_idle_pct) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(input logic [KEY_WIDTH-1:0] key);
		if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_axis_tdata <= TDATA_WIDTH'(key);
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		tracker.note_sample(key);
		items_sent++;
	endtask

	task automatic send_run(input logic [KEY_WIDTH-1:0] key, input int count);
		repeat (count) send_sample(key);
	endtask

	task automatic drain_events();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_events.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
			input logic [CFG_DATA_WIDTH-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		tracker.apply_reg(idx, val);
		reg_writes++;
	endtask

	task automatic set_config(input logic [KEY_WIDTH-1:0] nk, input logic [KEY_CODES-1:0] hm,
			input logic [KEY_CODES-1:0] rm, input logic [DEBOUNCE_WIDTH-1:0] db,
			input logic [HOLD_WIDTH-1:0] hd);
		drain_events();
		write_reg(REG_NO_KEY, CFG_DATA_WIDTH'(nk));
		write_reg(REG_HOLD_MASK, CFG_DATA_WIDTH'(hm));
		write_reg(REG_REPEAT_MASK, CFG_DATA_WIDTH'(rm));
		write_reg(REG_DEBOUNCE, CFG_DATA_WIDTH'(db));
		write_reg(REG_HOLD, CFG_DATA_WIDTH'(hd));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic [KEY_WIDTH-1:0] pick_real_key();
		logic [KEY_WIDTH-1:0] k;
		do k = KEY_WIDTH'($urandom_range(0, KEY_CODES - 1)); while (k == tracker.no_key);
		return k;
	endfunction

	// Run lengths cluster around the debounce threshold, with some long enough to hold.
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return int'(tracker.debounce) + $urandom_range(0, 5);
		else if (r < 85)
			return int'(tracker.hold) + 1 + $urandom_range(0, 40);
		else
			return $urandom_range(1, int'(tracker.debounce) + 2);
	endfunction

	task automatic key_sequence();
		logic [KEY_WIDTH-1:0] k;
		repeat ($urandom_range(0, 3))
			send_run(KEY_WIDTH'($urandom_range(0, KEY_CODES - 1)), $urandom_range(1, 2));
		k = ($urandom_range(0, 9) == 0) ? tracker.no_key : pick_real_key();
		send_run(k, pick_len());
		send_run(tracker.no_key, pick_len());
	endtask

	initial begin
		int phase;
		int rand_start;
		int phase_end;
		logic [KEY_WIDTH-1:0] k;
		logic [KEY_WIDTH-1:0] prev;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 20;
		rx_idle_pct = 20;
		foreach (directed_keys[i])
			send_sample(KEY_WIDTH'(directed_keys[i]));

		phase = 0;
		rand_start = items_sent;
		while (items_sent - rand_start < RANDOM_SAMPLES) begin
			case (phase)
				0: set_config('0, '1, '1, 7'd1, 16'd128);
				1: set_config(5'd31, '0, '0, 7'd127, 16'd128);
				2: set_config(5'd31, KEY_CODES'($urandom), KEY_CODES'($urandom),
					DEBOUNCE_WIDTH'($urandom_range(1, 8)), 16'd128);
				default: set_config(KEY_WIDTH'($urandom_range(0, 31)), KEY_CODES'($urandom),
					KEY_CODES'($urandom), DEBOUNCE_WIDTH'($urandom_range(1, 12)),
					HOLD_WIDTH'($urandom_range(128, 200)));
			endcase
			case ($urandom_range(0, 2))
				0: tx_idle_pct = 0;
				1: tx_idle_pct = 10;
				default: tx_idle_pct = 30;
			endcase
			case ($urandom_range(0, 2))
				0: rx_idle_pct = 0;
				1: rx_idle_pct = 10;
				default: rx_idle_pct = 30;
			endcase
			phase_end = items_sent + PHASE_SAMPLES;
			while (items_sent < phase_end)
				key_sequence();
			phase++;
		end

		// Back-to-back events while the output side is held off, so the input must stall.
		set_config(5'd31, KEY_CODES'($urandom), KEY_CODES'($urandom), 7'd1, 16'd128);
		tx_idle_pct = 0;
		rx_holdoff_req = 400;
		prev = tracker.last_sample;
		repeat (80) begin
			do k = pick_real_key(); while (k == prev);
			send_run(k, 2);
			prev = k;
		end

		set_config(5'd31, KEY_CODES'($urandom), KEY_CODES'($urandom), RESET_DEBOUNCE, RESET_HOLD);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (3) key_sequence();

		drain_events();
		if (tracker.pending_events.size() != 0)
			tracker.flag($sformatf("%0d expected events never arrived",
				tracker.pending_events.size()));
		$display("Run covered %0d key samples and %0d events over %0d register settings,",
			items_sent, tracker.events_seen, settings_used);
		$display("with %0d register writes and a long output stall that backed up the input.",
			reg_writes);
		if (tracker.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/kdhr_pkg.sv
design/kdhr_cfg.sv
design/kdhr_step.sv
design/kdhr_out.sv
design/keypad_debounce_hold_repeat_core.sv
tb/sv/tb_top.sv
